### sv/rrd_pkg.sv
package rrd_pkg;

  // item operation, carried in tuser
  localparam logic CMD_REFLECT = 1'b0;
  localparam logic CMD_REFRACT = 1'b1;

  // integer square root: 64-bit radicand, one root bit per stage
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_STEPS = ROOT_W;

  // final divide: (mag << 15) + len over 2 * len, quotient below 2^15
  localparam int NUM_W     = 46;
  localparam int DEN_W     = 32;
  localparam int QUO_W     = 15;
  localparam int DIV_STEPS = QUO_W;

endpackage

### sv/rrd_sqrt.sv
module rrd_sqrt
  import rrd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];
  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rad_p  = rad_q[j-1];
    end

    // bring down the next two radicand bits, try (2*root)*2 + 1
    assign cur   = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_p, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_q[j]  <= REM_W'(cur - trial);
          root_q[j] <= {root_p[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= cur[REM_W-1:0];
          root_q[j] <= {root_p[ROOT_W-2:0], 1'b0};
        end
        rad_q[j] <= {rad_p[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQ_STEPS-1];

endmodule

### sv/rrd_div.sv
module rrd_div
  import rrd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_q [DIV_STEPS];
  logic [DEN_W-1:0] den_q [DIV_STEPS];
  logic [QUO_W-1:0] quo_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int Bit = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p;
    logic [NUM_W:0]   sub;

    if (j == 0) begin : g_first
      assign rem_p = num;
      assign den_p = den;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end

    assign sub = (NUM_W+1)'(den_p) << Bit;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_p} >= sub) begin
          rem_q[j] <= NUM_W'({1'b0, rem_p} - sub);
          quo_q[j] <= quo_p | (QUO_W'(1) << Bit);
        end else begin
          rem_q[j] <= rem_p;
          quo_q[j] <= quo_p;
        end
        den_q[j] <= den_p;
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

### sv/ray_reflect_refract_direction.sv
// channel  dir  tdata                                             tuser
// s_axis   in   normal_x/y/z, incident_x/y/z, index_from, index_to cmd
// m_axis   out  out_x, out_y, out_z                              total_reflection
//
// One item per clock unless m_axis stalls; items pass through the two 32-stage
// square root pipelines (refraction root and normalization length) and the
// 15-stage divider. Reset clears only the valid bits. A stall on m_axis freezes the
// whole pipeline; s_axis_tready drops in the same cycle and nothing is lost.
module ray_reflect_refract_direction
  import rrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_x, normal_y, normal_z, incident_x, incident_y, incident_z,
  // index_from, index_to
  input  logic [127:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [47:0]  m_axis_tdata,
  // total_reflection
  output logic         m_axis_tuser
);

  localparam int ST_K   = 7;
  localparam int ST_Q   = ST_K + SQ_STEPS;
  localparam int ST_SUM = ST_Q + 8;
  localparam int ST_L   = ST_SUM + SQ_STEPS;
  localparam int ST_NUM = ST_L + 1;
  localparam int ST_QUO = ST_NUM + DIV_STEPS;
  localparam int LAT    = ST_QUO + 1;

  typedef struct packed {
    logic             tir;
    logic             mirror;
    logic [2:0][15:0] n;
    logic [2:0][32:0] fd;
    logic [34:0]      fc;
    logic [2:0][50:0] r;
  } side_a_t;

  typedef struct packed {
    logic [2:0][29:0] sh;
    logic [2:0]       neg;
    logic             zero;
    logic             tir;
  } side_b_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       tir;
  } side_c_t;

  logic           en;
  logic [LAT-1:0] vld;

  logic signed [15:0] in_n [3];
  logic signed [15:0] in_d [3];
  logic [15:0]        in_f;
  logic [15:0]        in_t;

  // stage registers
  logic               cmd1, cmd2, cmd3, cmd4, cmd5, cmd6;
  logic signed [15:0] n1 [3], n2 [3], n3 [3], n4 [3], n5 [3], n6 [3];
  logic signed [15:0] d1 [3], d2 [3], d3 [3];
  logic signed [31:0] prod1 [3];
  logic signed [32:0] fd1 [3], fd2 [3], fd3 [3], fd4 [3], fd5 [3], fd6 [3];
  logic [31:0]        ff1, ff2, ff3, ff4, ff5;
  logic [31:0]        tt1, tt2, tt3, tt4, tt5;
  logic [15:0]        f1, f2, f3;
  logic signed [33:0] dot2;
  logic [16:0]        cm3;
  logic               cneg3;
  logic signed [49:0] dn3 [3];
  logic [32:0]        cc4;
  logic signed [34:0] fc4, fc5, fc6;
  logic signed [50:0] r4 [3], r5 [3], r6 [3];
  logic [32:0]        s5;
  logic [63:0]        rhs6, lhs6;
  logic [63:0]        k7;
  side_a_t            sa7;
  side_a_t            sa_q [SQ_STEPS];
  logic [ROOT_W-1:0]  q_root;

  logic signed [35:0] a8;
  logic               mirror8, tir8, mirror9, tir9, tir10, tir11, tir12, tir13, tir14;
  logic signed [15:0] n8 [3];
  logic signed [32:0] fd8 [3], fd9 [3];
  logic signed [50:0] r8 [3], r9 [3];
  logic signed [51:0] an9 [3];
  logic signed [53:0] v10 [3];
  logic [52:0]        mag11 [3], mag12 [3];
  logic [2:0]         neg11, neg12, neg13, neg14;
  logic [52:0]        m11;
  logic [5:0]         lead12;
  logic               zero12, zero13, zero14;
  logic [29:0]        sh13 [3], sh14 [3];
  logic [59:0]        sq14 [3];
  logic [61:0]        sum15;
  side_b_t            sb15;
  side_b_t            sb_q [SQ_STEPS];
  logic [ROOT_W-1:0]  l_root;

  logic [NUM_W-1:0]   num16 [3];
  logic [DEN_W-1:0]   den16;
  side_c_t            sc16;
  side_c_t            sc_q [DIV_STEPS];
  logic [QUO_W-1:0]   quo [3];

  logic [15:0]        out_q [3];
  logic               tir_out;

  // combinational helpers
  logic [33:0]        absd_c;
  logic [21:0]        rnd_c;
  logic signed [17:0] c_c;
  logic               tir_c;
  logic [52:0]        magc [3];
  logic [52:0]        m01_c;
  logic [5:0]         lead_c;
  logic [52:0]        shv_c [3];

  assign en            = ~vld[LAT-1] | m_axis_tready;
  assign s_axis_tready = en & ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid & s_axis_tready};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_n[i] = s_axis_tdata[16*i +: 16];
      in_d[i] = s_axis_tdata[48+16*i +: 16];
    end
    in_f = s_axis_tdata[111:96];
    in_t = s_axis_tdata[127:112];
  end

  // cosine: round |dot| to 2^16 scale, clamp to one; total reflection test
  always_comb begin
    absd_c = dot2[33] ? 34'(-dot2) : 34'(dot2);
    rnd_c  = 22'((absd_c + 34'd2048) >> 12);
    c_c    = cneg3 ? -$signed({1'b0, cm3}) : $signed({1'b0, cm3});
    tir_c  = (cmd6 == CMD_REFRACT) && (rhs6 > lhs6);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magc[i] = v10[i][53] ? 53'(-v10[i]) : 53'(v10[i]);
    end
    m01_c = (magc[0] > magc[1]) ? magc[0] : magc[1];
  end

  always_comb begin
    lead_c = '0;
    for (int k = 0; k < 53; k++) begin
      if (m11[k]) begin
        lead_c = 6'(k);
      end
    end
  end

  // bring the largest magnitude to bit 29
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead12 >= 6'd29) begin
        shv_c[i] = mag12[i] >> (lead12 - 6'd29);
      end else begin
        shv_c[i] = mag12[i] << (6'd29 - lead12);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      cmd1 <= s_axis_tuser;
      f1   <= in_f;
      ff1  <= in_f * in_f;
      tt1  <= in_t * in_t;
      for (int i = 0; i < 3; i++) begin
        n1[i]    <= in_n[i];
        d1[i]    <= in_d[i];
        prod1[i] <= in_n[i] * in_d[i];
        fd1[i]   <= $signed({1'b0, in_f}) * in_d[i];
      end

      // dot product
      dot2 <= 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]);
      cmd2 <= cmd1;
      f2   <= f1;
      ff2  <= ff1;
      tt2  <= tt1;
      for (int i = 0; i < 3; i++) begin
        n2[i]  <= n1[i];
        d2[i]  <= d1[i];
        fd2[i] <= fd1[i];
      end

      // cosine and dot * n
      cm3   <= (rnd_c > 22'd65536) ? 17'd65536 : rnd_c[16:0];
      cneg3 <= ~dot2[33] && (dot2 != 34'sd0);
      cmd3  <= cmd2;
      f3    <= f2;
      ff3   <= ff2;
      tt3   <= tt2;
      for (int i = 0; i < 3; i++) begin
        dn3[i] <= dot2 * n2[i];
        n3[i]  <= n2[i];
        d3[i]  <= d2[i];
        fd3[i] <= fd2[i];
      end

      // cos^2, f*cos, mirror vector
      cc4  <= cm3 * cm3;
      fc4  <= $signed({1'b0, f3}) * c_c;
      cmd4 <= cmd3;
      ff4  <= ff3;
      tt4  <= tt3;
      for (int i = 0; i < 3; i++) begin
        r4[i]  <= (51'(d3[i]) <<< 28) - (51'(dn3[i]) <<< 1);
        n4[i]  <= n3[i];
        fd4[i] <= fd3[i];
      end

      // sin^2
      s5   <= 33'h1_0000_0000 - cc4;
      cmd5 <= cmd4;
      ff5  <= ff4;
      tt5  <= tt4;
      fc5  <= fc4;
      for (int i = 0; i < 3; i++) begin
        r5[i]  <= r4[i];
        n5[i]  <= n4[i];
        fd5[i] <= fd4[i];
      end

      // both sides of the scaled Snell term
      rhs6 <= 64'(ff5) * 64'(s5);
      lhs6 <= {tt5, 32'h0};
      cmd6 <= cmd5;
      fc6  <= fc5;
      for (int i = 0; i < 3; i++) begin
        r6[i]  <= r5[i];
        n6[i]  <= n5[i];
        fd6[i] <= fd5[i];
      end

      // radicand, total reflection
      k7         <= tir_c ? 64'd0 : lhs6 - rhs6;
      sa7.tir    <= tir_c;
      sa7.mirror <= (cmd6 == CMD_REFLECT) | tir_c;
      sa7.fc     <= fc6;
      for (int i = 0; i < 3; i++) begin
        sa7.n[i]  <= n6[i];
        sa7.fd[i] <= fd6[i];
        sa7.r[i]  <= r6[i];
      end

      sa_q[0] <= sa7;
      for (int j = 1; j < SQ_STEPS; j++) begin
        sa_q[j] <= sa_q[j-1];
      end

      // n coefficient
      a8      <= 36'($signed(sa_q[SQ_STEPS-1].fc)) - $signed(36'(q_root));
      mirror8 <= sa_q[SQ_STEPS-1].mirror;
      tir8    <= sa_q[SQ_STEPS-1].tir;
      for (int i = 0; i < 3; i++) begin
        n8[i]  <= $signed(sa_q[SQ_STEPS-1].n[i]);
        fd8[i] <= $signed(sa_q[SQ_STEPS-1].fd[i]);
        r8[i]  <= $signed(sa_q[SQ_STEPS-1].r[i]);
      end

      mirror9 <= mirror8;
      tir9    <= tir8;
      for (int i = 0; i < 3; i++) begin
        an9[i] <= a8 * n8[i];
        fd9[i] <= fd8[i];
        r9[i]  <= r8[i];
      end

      // pick mirror or refracted vector
      tir10 <= tir9;
      for (int i = 0; i < 3; i++) begin
        v10[i] <= mirror9 ? 54'(r9[i]) : 54'(an9[i]) + (54'(fd9[i]) <<< 16);
      end

      tir11 <= tir10;
      m11   <= (m01_c > magc[2]) ? m01_c : magc[2];
      for (int i = 0; i < 3; i++) begin
        mag11[i] <= magc[i];
        neg11[i] <= v10[i][53];
      end

      tir12  <= tir11;
      lead12 <= lead_c;
      zero12 <= (m11 == 53'd0);
      neg12  <= neg11;
      for (int i = 0; i < 3; i++) begin
        mag12[i] <= mag11[i];
      end

      tir13  <= tir12;
      zero13 <= zero12;
      neg13  <= neg12;
      for (int i = 0; i < 3; i++) begin
        sh13[i] <= shv_c[i][29:0];
      end

      tir14  <= tir13;
      zero14 <= zero13;
      neg14  <= neg13;
      for (int i = 0; i < 3; i++) begin
        sq14[i] <= sh13[i] * sh13[i];
        sh14[i] <= sh13[i];
      end

      sum15     <= 62'(sq14[0]) + 62'(sq14[1]) + 62'(sq14[2]);
      sb15.tir  <= tir14;
      sb15.zero <= zero14;
      sb15.neg  <= neg14;
      for (int i = 0; i < 3; i++) begin
        sb15.sh[i] <= sh14[i];
      end

      sb_q[0] <= sb15;
      for (int j = 1; j < SQ_STEPS; j++) begin
        sb_q[j] <= sb_q[j-1];
      end

      // rounded quotient setup: (mag * 2^15 + len) / (2 * len)
      den16     <= {l_root[DEN_W-2:0], 1'b0};
      sc16.neg  <= sb_q[SQ_STEPS-1].neg;
      sc16.zero <= sb_q[SQ_STEPS-1].zero;
      sc16.tir  <= sb_q[SQ_STEPS-1].tir;
      for (int i = 0; i < 3; i++) begin
        num16[i] <= NUM_W'({sb_q[SQ_STEPS-1].sh[i], 15'h0}) + NUM_W'(l_root);
      end

      sc_q[0] <= sc16;
      for (int j = 1; j < DIV_STEPS; j++) begin
        sc_q[j] <= sc_q[j-1];
      end

      tir_out <= sc_q[DIV_STEPS-1].tir;
      for (int i = 0; i < 3; i++) begin
        if (sc_q[DIV_STEPS-1].zero) begin
          out_q[i] <= '0;
        end else if (sc_q[DIV_STEPS-1].neg[i]) begin
          out_q[i] <= -16'(quo[i]);
        end else begin
          out_q[i] <= 16'(quo[i]);
        end
      end
    end
  end

  rrd_sqrt u_sqrt_k (
    .clk  (clk),
    .en   (en),
    .rad  (k7),
    .root (q_root)
  );

  rrd_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'(sum15)),
    .root (l_root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rrd_div u_div (
      .clk (clk),
      .en  (en),
      .num (num16[i]),
      .den (den16),
      .quo (quo[i])
    );
  end

  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};
  assign m_axis_tuser  = tir_out;

`ifndef NO_ASSERTIONS
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0])  <= 16'sd16384) &&
      ($signed(m_axis_tdata[15:0])  >= -16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[31:16]) >= -16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("result component out of unit range");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_L-1] && !sb_q[SQ_STEPS-1].zero |->
      (l_root[ROOT_W-1] == 1'b0) && (l_root[ROOT_W-2:ROOT_W-3] != 2'b00))
    else $error("normalized length outside expected window");
`endif

endmodule

### tb/tb_top.sv
module tb_top
  import rrd_pkg::*;
();

  localparam int LATENCY = 96;

  typedef struct {
    logic        cmd;
    logic [15:0] nrm [3];
    logic [15:0] inc [3];
    logic [15:0] idx_from;
    logic [15:0] idx_to;
  } ray_t;

  typedef struct {
    logic [15:0] dir [3];
    logic        tir;
  } dir_t;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  class direction_scoreboard;
    dir_t pending[$];
    int   errors;
    int   checked;
    int   tir_seen;

    function automatic void unit_vector(input longint v [3], output logic [15:0] o [3]);
      logic [63:0] mag [3];
      logic [63:0] m, sum, len, q;
      logic        neg [3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) o[i] = '0;
        return;
      end
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 15) + len) / (len << 1);
        o[i] = neg[i] ? 16'(-q) : 16'(q);
      end
    endfunction

    function void note_ray(input ray_t r);
      longint n [3], d [3], v [3];
      longint dot, craw, c, a, q;
      logic [63:0] cm, s, lhs, rhs, f, t;
      dir_t e;
      dot = 0;
      e.tir = 0;
      f = r.idx_from;
      t = r.idx_to;
      for (int i = 0; i < 3; i++) begin
        n[i] = longint'($signed(r.nrm[i]));
        d[i] = longint'($signed(r.inc[i]));
        dot += n[i] * d[i];
      end
      if (r.cmd == CMD_REFRACT) begin
        craw = -dot;
        cm = craw < 0 ? -craw : craw;
        cm = (cm + 2048) >> 12;
        if (cm > 65536) cm = 65536;
        c = craw < 0 ? -longint'(cm) : longint'(cm);
        s = (64'd1 << 32) - cm * cm;
        lhs = (t * t) << 32;
        rhs = (f * f) * s;
        if (rhs > lhs) begin
          e.tir = 1;
        end else begin
          q = longint'(isqrt(lhs - rhs));
          a = longint'(f) * c - q;
          for (int i = 0; i < 3; i++) v[i] = a * n[i] + longint'(f) * d[i] * 65536;
        end
      end
      if (r.cmd == CMD_REFLECT || e.tir) begin
        for (int i = 0; i < 3; i++) v[i] = d[i] * 64'sd268435456 - 2 * dot * n[i];
      end
      unit_vector(v, e.dir);
      pending.insert(pending.size(), e);
    endfunction

    function void check_dir(input logic [47:0] data, input logic tuser);
      dir_t e;
      string nm [3];
      nm = '{"out_x", "out_y", "out_z"};
      if (pending.size() == 0) begin
        $error("unexpected result data=%h tuser=%b", data, tuser);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.tir) tir_seen++;
      for (int i = 0; i < 3; i++)
        if (data[16*i +: 16] !== e.dir[i]) begin
          $error("%s: expected %0d, got %0d", nm[i], $signed(e.dir[i]),
                 $signed(data[16*i +: 16]));
          errors++;
        end
      if (tuser !== e.tir) begin
        $error("total_reflection: expected %0b, got %0b", e.tir, tuser);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  direction_scoreboard sb = new();
  int  sent;
  bit  calm;          // no idling in the last part
  bit  long_hold;     // receiver holds off on request

  ray_reflect_refract_direction dut (.*);

  always #10 clk = ~clk;

  function automatic logic [127:0] pack_ray(input ray_t r);
    return {r.idx_to, r.idx_from, r.inc[2], r.inc[1], r.inc[0],
            r.nrm[2], r.nrm[1], r.nrm[0]};
  endfunction

  // Random vector near unit length, an axis vector, or raw noise now and then.
  function automatic void rand_unit(output logic [15:0] v [3]);
    int x, y, z, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      for (int i = 0; i < 3; i++) v[i] = 16'($urandom);
      return;
    end
    if (pick == 1) begin
      x = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) v[i] = '0;
      v[x] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      return;
    end
    x = $urandom_range(0, 16384);
    y = $urandom_range(0, $rtoi($sqrt(real'(16384*16384 - x*x))));
    z = $rtoi($sqrt(real'(16384*16384 - x*x - y*y)));
    v[0] = $urandom_range(0, 1) ? 16'(x) : 16'(-x);
    v[1] = $urandom_range(0, 1) ? 16'(y) : 16'(-y);
    v[2] = $urandom_range(0, 1) ? 16'(z) : 16'(-z);
  endfunction

  function automatic logic [15:0] rand_index();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      2: return 16'd8192;
      default: return 16'($urandom_range(8192, 24576));
    endcase
  endfunction

  task automatic send_ray(input ray_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tdata  <= pack_ray(r);
    s_axis_tuser  <= r.cmd;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_ray(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic make_ray(input logic cmd, input int nx, ny, nz, ix, iy, iz,
                          input int f, t, output ray_t r);
    r.cmd = cmd;
    r.nrm = '{16'(nx), 16'(ny), 16'(nz)};
    r.inc = '{16'(ix), 16'(iy), 16'(iz)};
    r.idx_from = 16'(f);
    r.idx_to = 16'(t);
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_dir(m_axis_tdata, m_axis_tuser);

  initial begin
    ray_t r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: axes, glancing hits, grazing and total reflection, zero and extreme vectors, odd indices
    make_ray(CMD_REFLECT, 0, 0, 16384, 0, 0, -16384, 8192, 8192, r); send_ray(r);
    make_ray(CMD_REFLECT, 16384, 0, 0, 11585, 11585, 0, 8192, 8192, r); send_ray(r);
    make_ray(CMD_REFLECT, 0, 0, 0, 0, 0, 0, 8192, 8192, r); send_ray(r);
    make_ray(CMD_REFLECT, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, r); send_ray(r);
    make_ray(CMD_REFLECT, 0, 16384, 0, 0, 16384, 0, 65535, 65535, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 0, 0, -16384, 8192, 12288, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 11585, 0, -11585, 8192, 12288, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 11585, 0, -11585, 12288, 8192, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 16384, 0, 0, 12288, 8192, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 16384, 0, 0, 8192, 8192, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 0, 0, -16384, 0, 8192, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 0, 0, -16384, 8192, 0, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 11585, 0, -11585, 8192, 0, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 0, 0, 0, 0, 0, 0, r); send_ray(r);
    make_ray(CMD_REFRACT, 32767, 32767, 32767, -32768, -32768, -32768, 65535, 1, r);
    send_ray(r);
    make_ray(CMD_REFRACT, -32768, 0, 0, -32768, 0, 0, 65535, 65535, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, -16384, 0, 0, 16384, 0, 8192, 65535, r); send_ray(r);
    make_ray(CMD_REFRACT, 0, 0, 16384, 16384, 0, -1, 8192, 8192, r); send_ray(r);

    // sender pause until everything is back
    drain();

    for (int k = 0; k < 1850; k++) begin
      if (k == 400) long_hold = 1;
      if (k == 1600) calm = 1;
      r.cmd = 1'($urandom);
      rand_unit(r.nrm);
      rand_unit(r.inc);
      r.idx_from = rand_index();
      r.idx_to = rand_index();
      send_ray(r);
    end
    drain();
    repeat (LATENCY + 20) @(negedge clk);

    $display("Sent %0d rays, checked %0d directions (%0d total reflections).",
             sent, sb.checked, sb.tir_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
